/* src/mouse_packet_decoder_with_event_fifo_top_assert.svh */
// Assertion macros shared by the mouse packet decoder.
// Both expect clk and arst_n in scope at the point of use.
`ifndef MOUSE_PACKET_DECODER_WITH_EVENT_FIFO_TOP_ASSERT_SVH
`define MOUSE_PACKET_DECODER_WITH_EVENT_FIFO_TOP_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define MPD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define MPD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/mpd_pkg.sv */
package mpd_pkg;

	localparam logic [7:0] BYTE_ACK      = 8'hFA;
	localparam logic [7:0] BYTE_SELFTEST = 8'hAA;
	localparam int         HDR_SYNC_BIT  = 3;
	localparam logic [7:0] HDR_OVF_MASK  = 8'hC0;
	localparam int         HDR_LEFT_BIT  = 0;
	localparam int         COUNT_W       = 7;

	typedef enum logic {
		OP_BYTE    = 1'b0,
		OP_SERVICE = 1'b1
	} opcode_t;

	// One stored event, laid out as dx in bits 7..0, dy in 16..8, left in 17.
	typedef struct packed {
		logic              left;
		logic signed [8:0] dy;
		logic signed [7:0] dx;
	} event_t;

	typedef struct packed {
		logic   push;
		event_t entry;
	} push_t;

endpackage

/* src/mpd_ifs.sv */
interface mpd_req_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] rx_byte;

	modport source (output valid, output opcode, output rx_byte, input ready);
	modport sink (input valid, input opcode, input rx_byte, output ready);
endinterface

interface mpd_rsp_if;
	logic              valid;
	logic              ready;
	logic              event_valid;
	logic signed [7:0] move_x;
	logic signed [8:0] move_y;
	logic              left_button;
	logic [6:0]        queue_count;
	logic              overflow_seen;

	modport source (output valid, output event_valid, output move_x, output move_y,
		output left_button, output queue_count, output overflow_seen, input ready);
	modport sink (input valid, input event_valid, input move_x, input move_y,
		input left_button, input queue_count, input overflow_seen, output ready);
endinterface

interface mpd_cfg_if;
	logic valid;
	logic ready;
	logic consumer_enabled;

	modport source (output valid, output consumer_enabled, input ready);
	modport sink (input valid, input consumer_enabled, output ready);
endinterface

/* src/mpd_packet_asm.sv */
module mpd_packet_asm (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           byte_go,
	input  logic [7:0]     rx_byte,
	output mpd_pkg::push_t push
);
	import mpd_pkg::*;

	typedef enum logic [2:0] {
		POS_HDR = 3'b001,
		POS_X   = 3'b010,
		POS_Y   = 3'b100
	} pos_t;

	pos_t       pos_q;
	pos_t       pos_n;
	logic [7:0] header_q;
	logic [7:0] x_q;
	logic       restart;
	logic [8:0] y_sext;

	assign restart = (rx_byte == BYTE_ACK) || (rx_byte == BYTE_SELFTEST);
	assign y_sext  = {rx_byte[7], rx_byte};

	always_comb begin
		pos_n      = pos_q;
		push.push  = 1'b0;
		push.entry.dx   = x_q;
		push.entry.dy   = 9'd0 - y_sext;
		push.entry.left = header_q[HDR_LEFT_BIT];
		if (byte_go) begin
			if (restart) begin
				pos_n = POS_HDR;
			end else begin
				case (pos_q)
					POS_HDR: begin
						if (rx_byte[HDR_SYNC_BIT]) begin
							pos_n = POS_X;
						end
					end
					POS_X: begin
						pos_n = POS_Y;
					end
					default: begin
						// Third byte closes the packet; overflowed packets are dropped.
						pos_n     = POS_HDR;
						push.push = ((header_q & HDR_OVF_MASK) == 8'd0);
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_HDR;
		end else begin
			pos_q <= pos_n;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_go && !restart && pos_q == POS_HDR && rx_byte[HDR_SYNC_BIT]) begin
			header_q <= rx_byte;
		end
		if (byte_go && !restart && pos_q == POS_X) begin
			x_q <= rx_byte;
		end
	end

endmodule

/* src/mouse_packet_decoder_with_event_fifo_top.sv */
// The decoder takes one word per cycle on req while rsp is ready: either a byte
// received from the PS/2 auxiliary port or a service request, and returns exactly
// one result word on rsp for each, via stage 1 and the output register. Bytes are
// gathered into three-byte packets; a complete packet without overflow bits
// becomes an event in a ring of QUEUE_SLOTS entries, which holds at most
// QUEUE_SLOTS - 1 events and drops its oldest event when full. A service
// request pops one event when consumer_enabled is set and flushes the ring
// otherwise. The ring lives in one synchronous memory: a push writes it in the
// accept cycle, a pop reads it in the accept cycle and the data appears in the
// next stage, so one word is taken every cycle while rsp is ready. With rsp
// stalled the block keeps taking words until both stages hold one; from then on
// req.ready follows rsp.ready in the same cycle. The configuration register is
// always ready and should be written only while the block is idle.
module mouse_packet_decoder_with_event_fifo_top #(
	parameter int QUEUE_SLOTS = 128
) (
	input logic          clk,
	input logic          arst_n,
	mpd_req_if.sink      req,
	mpd_rsp_if.source    rsp,
	mpd_cfg_if.sink      cfg
);
	import mpd_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_SLOTS);
	localparam int CNT_W = (PTR_W + 1 > COUNT_W) ? PTR_W + 1 : COUNT_W;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_SLOTS - 1);

	// Event memory.
	event_t mem [QUEUE_SLOTS];
	event_t rd_data_q;

	// Ring and configuration state.
	logic             ce_q;
	logic [PTR_W-1:0] wp_q;
	logic [PTR_W-1:0] rp_q;
	logic             flag_q;
	logic [PTR_W-1:0] wp_n;
	logic [PTR_W-1:0] rp_n;
	logic             flag_n;
	logic [PTR_W-1:0] wp_inc;
	logic [PTR_W-1:0] rp_inc;
	logic [CNT_W-1:0] cnt_wide;

	// Handshake and control.
	logic  req_acc;
	logic  byte_go;
	logic  pop_go;
	logic  flush_go;
	push_t push;

	// Stage 1: result waiting for the memory read data.
	logic               valid_s1;
	logic               evt_s1;
	logic [COUNT_W-1:0] count_s1;
	logic               flag_s1;
	logic               s1_adv;

	// Stage 2: output register.
	logic out_valid_q;

	assign cfg.ready = 1'b1;

	// Stage 1 moves on when the output register is free or being drained.
	assign s1_adv    = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || s1_adv;
	assign req_acc   = req.valid && req.ready;
	assign byte_go   = req_acc && (req.opcode == OP_BYTE);
	assign pop_go    = req_acc && (req.opcode == OP_SERVICE) && ce_q && (wp_q != rp_q);
	assign flush_go  = req_acc && (req.opcode == OP_SERVICE) && !ce_q;

	mpd_packet_asm u_asm (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_go (byte_go),
		.rx_byte (req.rx_byte),
		.push    (push)
	);

	assign wp_inc = (wp_q == PTR_LAST) ? '0 : wp_q + 1'b1;
	assign rp_inc = (rp_q == PTR_LAST) ? '0 : rp_q + 1'b1;

	always_comb begin
		wp_n   = wp_q;
		rp_n   = rp_q;
		flag_n = flag_q;
		if (push.push) begin
			wp_n = wp_inc;
			// A full ring loses its oldest event.
			if (wp_inc == rp_q) begin
				rp_n   = rp_inc;
				flag_n = 1'b1;
			end
		end else if (pop_go) begin
			rp_n = rp_inc;
			if (wp_q == rp_inc) begin
				flag_n = 1'b0;
			end
		end else if (flush_go) begin
			wp_n   = '0;
			rp_n   = '0;
			flag_n = 1'b0;
		end
	end

	// Occupancy after this word, wrapped at the ring size.
	always_comb begin
		cnt_wide = CNT_W'(wp_n) - CNT_W'(rp_n);
		if (wp_n < rp_n) begin
			cnt_wide = cnt_wide + CNT_W'(QUEUE_SLOTS);
		end
	end

	always_ff @(posedge clk) begin
		if (push.push) begin
			mem[wp_q] <= push.entry;
		end
		if (pop_go) begin
			rd_data_q <= mem[rp_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ce_q        <= 1'b0;
			wp_q        <= '0;
			rp_q        <= '0;
			flag_q      <= 1'b0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				ce_q <= cfg.consumer_enabled;
			end
			wp_q   <= wp_n;
			rp_q   <= rp_n;
			flag_q <= flag_n;
			if (req_acc) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			evt_s1   <= pop_go;
			count_s1 <= cnt_wide[COUNT_W-1:0];
			flag_s1  <= flag_n;
		end
		if (s1_adv) begin
			rsp.event_valid   <= evt_s1;
			rsp.move_x        <= evt_s1 ? rd_data_q.dx : 8'sd0;
			rsp.move_y        <= evt_s1 ? rd_data_q.dy : 9'sd0;
			rsp.left_button   <= evt_s1 && rd_data_q.left;
			rsp.queue_count   <= count_s1;
			rsp.overflow_seen <= flag_s1;
		end
	end

	assign rsp.valid = out_valid_q;

`include "mouse_packet_decoder_with_event_fifo_top_assert.svh"

	// A flush leaves the ring empty with the overflow flag cleared.
	`MPD_ASSERT_NEXT(a_flush_clears, flush_go,
		(wp_q == '0) && (rp_q == '0) && !flag_q, "flush did not clear the ring")
	// The sticky overflow flag is only ever set while events are held.
	`MPD_ASSERT_NOW(a_flag_nonempty, flag_q, wp_q != rp_q,
		"overflow flag set on an empty ring")
	// A stalled first stage keeps its popped read data.
	`MPD_ASSERT_NEXT(a_s1_hold, valid_s1 && !s1_adv,
		valid_s1 && $stable(evt_s1) && (!evt_s1 || $stable(rd_data_q)),
		"stalled stage lost its data")

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

// Self-checking bench for the PS/2 mouse packet decoder with its event ring.
// Every word sent on req (a port byte or a service request) is run through a
// scoreboard that keeps its own copy of the packet assembler and the ring, and
// queues the one result word that the word must produce. Result words that come
// back on rsp are checked in order against that queue.
module tb_top;
	import mpd_pkg::*;

	localparam int SLOTS      = 128;
	localparam int LONG_HOLD  = 80;    // long stall of the result side
	localparam int QUIET_MAX  = 2000;  // cycles without any handshake before giving up
	localparam int TAIL_WAIT  = 8;     // extra wait after the last result word

	// One result word as it appears on the rsp channel.
	typedef struct packed {
		logic                     ev_valid;
		logic signed [7:0]        mx;
		logic signed [8:0]        my;
		logic                     lb;
		logic [COUNT_W-1:0]       cnt;
		logic                     ovf;
	} decoded_result_t;

	// The scoreboard tracks the packet assembler and the event ring, and holds
	// the result words still owed by the block.
	class mouse_event_scoreboard;
		bit              consumer_on;
		logic [1:0]      byte_slot;
		logic [7:0]      header;
		logic [7:0]      x_raw;
		event_t          ring[SLOTS];
		int              wr_ptr;
		int              rd_ptr;
		bit              dropped;
		decoded_result_t expected_results[$];
		int              errors;

		function new();
			consumer_on = 1'b0;
			byte_slot = '0;
			header = '0;
			x_raw = '0;
			wr_ptr = 0;
			rd_ptr = 0;
			dropped = 1'b0;
			errors = 0;
		endfunction

		function void set_consumer(bit on);
			consumer_on = on;
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		// A full ring loses its oldest event to make room for the new one.
		function void push_event(event_t ev);
			int nxt;
			nxt = (wr_ptr + 1) % SLOTS;
			if (nxt == rd_ptr) begin
				rd_ptr = (rd_ptr + 1) % SLOTS;
				dropped = 1'b1;
			end
			ring[wr_ptr] = ev;
			wr_ptr = nxt;
		endfunction

		function void decode_word(opcode_t op, logic [7:0] b);
			decoded_result_t r;
			event_t ev;
			r = '0;
			if (op == OP_BYTE) begin
				if (b == BYTE_ACK || b == BYTE_SELFTEST) begin
					byte_slot = 2'd0;
				end else if (byte_slot == 2'd0) begin
					if (b[HDR_SYNC_BIT]) begin
						header = b;
						byte_slot = 2'd1;
					end
				end else if (byte_slot == 2'd1) begin
					x_raw = b;
					byte_slot = 2'd2;
				end else begin
					byte_slot = 2'd0;
					if ((header & HDR_OVF_MASK) == 8'h00) begin
						ev.dx = x_raw;
						ev.dy = 9'(0) - {b[7], b};
						ev.left = header[HDR_LEFT_BIT];
						push_event(ev);
					end
				end
			end else if (!consumer_on) begin
				wr_ptr = 0;
				rd_ptr = 0;
				dropped = 1'b0;
			end else if (wr_ptr != rd_ptr) begin
				ev = ring[rd_ptr];
				rd_ptr = (rd_ptr + 1) % SLOTS;
				if (wr_ptr == rd_ptr)
					dropped = 1'b0;
				r.ev_valid = 1'b1;
				r.mx = ev.dx;
				r.my = ev.dy;
				r.lb = ev.left;
			end
			r.cnt = COUNT_W'((wr_ptr + SLOTS - rd_ptr) % SLOTS);
			r.ovf = dropped;
			expected_results.push_back(r);
		endfunction

		function void report(string what, decoded_result_t e, decoded_result_t a);
			errors++;
			if (errors <= 10) begin
				$display("%0t: %s: expected valid=%0d dx=%0d dy=%0d left=%0d count=%0d ovf=%0d",
					$realtime, what, e.ev_valid, e.mx, e.my, e.lb, e.cnt, e.ovf);
				$display("    got valid=%0d dx=%0d dy=%0d left=%0d count=%0d ovf=%0d",
					a.ev_valid, a.mx, a.my, a.lb, a.cnt, a.ovf);
			end
		endfunction

		function void check_result(decoded_result_t a);
			decoded_result_t e;
			if (expected_results.size() == 0) begin
				report("result word with nothing pending", '0, a);
			end else begin
				e = expected_results.pop_front();
				if (e.ev_valid !== a.ev_valid || e.mx !== a.mx || e.my !== a.my ||
				    e.lb !== a.lb || e.cnt !== a.cnt || e.ovf !== a.ovf)
					report("result word mismatch", e, a);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	mpd_req_if req_ch();
	mpd_rsp_if rsp_ch();
	mpd_cfg_if cfg_ch();

	mouse_packet_decoder_with_event_fifo_top #(
		.QUEUE_SLOTS(SLOTS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch),
		.cfg   (cfg_ch)
	);

	mouse_event_scoreboard sb = new();

	// idle_on enables random bubbles on both sides; long_hold_req asks the
	// result side for one long stall so that the block backs up into req.
	bit idle_on = 1'b1;
	bit long_hold_req = 1'b0;
	int words_sent = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Result side: checks each accepted word, then decides whether to take the
	// next one. Sampling right after the edge sees the values from before it.
	initial begin : result_sink
		int hold_left;
		decoded_result_t seen;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (rsp_ch.valid && rsp_ch.ready) begin
					seen.ev_valid = rsp_ch.event_valid;
					seen.mx = rsp_ch.move_x;
					seen.my = rsp_ch.move_y;
					seen.lb = rsp_ch.left_button;
					seen.cnt = rsp_ch.queue_count;
					seen.ovf = rsp_ch.overflow_seen;
					sb.check_result(seen);
				end
				if (hold_left > 0) begin
					hold_left--;
					rsp_ch.ready <= 1'b0;
				end else if (long_hold_req) begin
					long_hold_req = 1'b0;
					hold_left = LONG_HOLD - 1;
					rsp_ch.ready <= 1'b0;
				end else if (idle_on && $urandom_range(0, 99) < 10) begin
					hold_left = $urandom_range(1, 18) - 1;
					rsp_ch.ready <= 1'b0;
				end else begin
					rsp_ch.ready <= 1'b1;
				end
			end
		end
	end

	// Watchdog: any handshake on any channel counts as progress.
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
		    (cfg_ch.valid && cfg_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (arst_n && quiet_cycles >= QUIET_MAX) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Offers one word and returns at the edge where it is taken. The valid stays
	// high after that, so back-to-back calls keep the channel full unless idle_on adds a gap.
	task automatic send_word(input opcode_t op, input logic [7:0] b);
		int gap;
		if (idle_on && $urandom_range(0, 99) < 12) begin
			req_ch.valid <= 1'b0;
			gap = $urandom_range(1, 18);
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.opcode <= op;
		req_ch.rx_byte <= b;
		do @(posedge clk); while (!req_ch.ready);
		sb.decode_word(op, b);
		words_sent++;
	endtask

	task automatic send_packet(input logic [7:0] h, input logic [7:0] x, input logic [7:0] y);
		send_word(OP_BYTE, h);
		send_word(OP_BYTE, x);
		send_word(OP_BYTE, y);
	endtask

	// A header that passes sync and, unless overflow is wanted, has no
	// overflow bits. A header without overflow bits can never be a restart byte.
	function automatic logic [7:0] random_header(input bit allow_ovf);
		logic [7:0] h;
		h = 8'($urandom_range(0, 255));
		h[HDR_SYNC_BIT] = 1'b1;
		if (!allow_ovf)
			h = h & ~HDR_OVF_MASK;
		return h;
	endfunction

	// Mostly complete packets with random content; the rest are service
	// requests, stray bytes, restart bytes and packets cut short.
	task automatic send_random_unit(input int service_pct);
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < service_pct) begin
			send_word(OP_SERVICE, 8'($urandom_range(0, 255)));
		end else if (pick < service_pct + 8) begin
			send_word(OP_BYTE, 8'($urandom_range(0, 255)));
		end else if (pick < service_pct + 11) begin
			send_word(OP_BYTE, ($urandom_range(0, 1) != 0) ? BYTE_ACK : BYTE_SELFTEST);
		end else if (pick < service_pct + 14) begin
			send_word(OP_BYTE, random_header($urandom_range(0, 99) < 15));
			if ($urandom_range(0, 1) != 0)
				send_word(OP_BYTE, 8'($urandom_range(0, 255)));
		end else begin
			send_packet(random_header($urandom_range(0, 99) < 15),
				8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		end
	endtask

	// Stops offering and waits until every owed result word has come back.
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// The register is only written while nothing is in flight.
	task automatic write_consumer(input bit on);
		cfg_ch.valid <= 1'b1;
		cfg_ch.consumer_enabled <= on;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.set_consumer(on);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin : stimulus
		int target;
		clk = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.opcode = OP_BYTE;
		req_ch.rx_byte = 8'h00;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.consumer_enabled = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_consumer(1'b1);

		// Directed words. A service request on an empty ring pops nothing, and
		// a first byte without the sync bit is skipped.
		send_word(OP_SERVICE, 8'h00);
		send_word(OP_BYTE, 8'h00);
		// Largest dx with the smallest dy, which negates to +128, left pressed.
		send_packet(8'h09, 8'h7F, 8'h80);
		// Smallest dx and largest dy.
		send_packet(8'h08, 8'h80, 8'h7F);
		send_packet(8'h0D, 8'hFF, 8'hFF);
		// Restart bytes in the third, second and first position are never stored.
		send_packet(8'h08, 8'h01, BYTE_ACK);
		send_word(OP_BYTE, 8'h08);
		send_word(OP_BYTE, BYTE_SELFTEST);
		send_word(OP_BYTE, BYTE_SELFTEST);
		// A packet with overflow bits in its header is dropped.
		send_packet(8'hC8, 8'h10, 8'h10);
		send_packet(8'h38, 8'h00, 8'h00);
		// Pop the four events, then one more on the empty ring.
		repeat (5) send_word(OP_SERVICE, 8'hFF);
		wait_drained();

		// Mixed traffic with a long stall of the result side early on, so the
		// block fills up and holds off req while words keep being offered.
		long_hold_req = 1'b1;
		target = words_sent + 450;
		while (words_sent < target)
			send_random_unit(25);
		wait_drained();

		// Fill the ring past capacity so that old events are lost and the
		// sticky flag rises, then pop until the ring is empty and beyond.
		repeat (170)
			send_packet(random_header(1'b0), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)));
		repeat (135) send_word(OP_SERVICE, 8'($urandom_range(0, 255)));
		wait_drained();

		// Without a consumer a service request flushes the whole ring.
		write_consumer(1'b0);
		target = words_sent + 400;
		while (words_sent < target)
			send_random_unit(8);
		wait_drained();

		// Last part runs at full rate on both sides.
		write_consumer(1'b1);
		idle_on = 1'b0;
		target = words_sent + 400;
		while (words_sent < target)
			send_random_unit(20);
		wait_drained();
		repeat (TAIL_WAIT) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
